@@ hdl/gps_pkg.sv @@
// Shared types, constants and a helper function of the galvo point sequencer.
package gps_pkg;

    localparam int POINT_DEPTH = 4096;
    localparam int PT_AW       = (POINT_DEPTH > 1) ? $clog2(POINT_DEPTH) : 1;

    localparam int CMD_W   = 3;
    localparam int IDX_W   = 12;
    localparam int CODE_W  = 16;
    localparam int DELAY_W = 32;
    localparam int CNT_W   = 13;
    localparam int DUTY_W  = 10;
    localparam int FRAME_W = 24;
    localparam int LASER_W = 20;
    localparam int ERR_W   = 2;
    localparam int STEP_W  = 3;
    localparam int PADDR_W = 3;

    localparam int POS_W = 2 * CODE_W;
    localparam int TIM_W = DUTY_W + DELAY_W;

    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_START  = 3'd1;
    localparam logic [CMD_W-1:0] CMD_TICK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_HOME   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SETPOS = 3'd4;
    localparam logic [CMD_W-1:0] CMD_INIT   = 3'd5;

    localparam logic [ERR_W-1:0] ERR_NONE     = 2'd0;
    localparam logic [ERR_W-1:0] ERR_DISABLED = 2'd1;
    localparam logic [ERR_W-1:0] ERR_RANGE    = 2'd2;

    localparam logic REG_ENABLE = 1'b0;

    localparam logic [7:0] DAC_CMD_A      = 8'h18;
    localparam logic [7:0] DAC_CMD_B      = 8'h19;
    localparam logic [7:0] DAC_CMD_RESET  = 8'h28;
    localparam logic [7:0] DAC_CMD_REF    = 8'h38;
    localparam logic [7:0] DAC_CMD_LDAC   = 8'h20;
    localparam logic [CODE_W-1:0] DAC_DATA_ONE  = 16'h0001;
    localparam logic [CODE_W-1:0] DAC_DATA_BOTH = 16'h0003;
    localparam logic [CODE_W-1:0] MID_CODE      = 16'd32768;

    localparam logic [DUTY_W-1:0]  DUTY_MAX        = 10'd1000;
    localparam logic [LASER_W-1:0] NS_PER_PERMILLE = 20'd1000;

    localparam logic [STEP_W-1:0] NRES_ONE   = 3'd1;
    localparam logic [STEP_W-1:0] NRES_TWO   = 3'd2;
    localparam logic [STEP_W-1:0] NRES_THREE = 3'd3;
    localparam logic [STEP_W-1:0] NRES_INIT  = 3'd5;

    typedef struct packed {
        logic              in_ready;
        logic              accept;
        logic              latch_point;
        logic              emit;
        logic [STEP_W-1:0] step;
    } t_dp_cmd;

    typedef struct packed {
        logic due;
        logic out_free;
        logic last;
    } t_dp_status;

    function automatic logic [FRAME_W-1:0] init_frame(input logic [STEP_W-1:0] step);
        logic [FRAME_W-1:0] f;
        unique case (step)
            3'd0:    f = {DAC_CMD_RESET, DAC_DATA_ONE};
            3'd1:    f = {DAC_CMD_REF, DAC_DATA_ONE};
            3'd2:    f = {DAC_CMD_LDAC, DAC_DATA_BOTH};
            3'd3:    f = {DAC_CMD_A, MID_CODE};
            default: f = {DAC_CMD_B, MID_CODE};
        endcase
        return f;
    endfunction

endpackage

@@ hdl/gps_req_if.sv @@
// Request channel interface carrying one command item.
interface gps_req_if
    import gps_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [IDX_W-1:0]   point_index;
    logic [CODE_W-1:0]  x_value;
    logic [CODE_W-1:0]  y_value;
    logic [CODE_W-1:0]  duty_permille;
    logic [DELAY_W-1:0] hold_us;
    logic [CNT_W-1:0]   point_count;

    modport source (
        output valid, command, point_index, x_value, y_value, duty_permille,
               hold_us, point_count,
        input  ready
    );
    modport sink (
        input  valid, command, point_index, x_value, y_value, duty_permille,
               hold_us, point_count,
        output ready
    );
endinterface

@@ hdl/gps_rsp_if.sv @@
// Result channel interface carrying one frame and status item.
interface gps_rsp_if
    import gps_pkg::*;
;
    logic               valid;
    logic               ready;
    logic               frame_valid;
    logic [FRAME_W-1:0] dac_frame;
    logic               last;
    logic [LASER_W-1:0] laser_duty_ns;
    logic               running;
    logic [CNT_W-1:0]   batch_points;
    logic [CNT_W-1:0]   played_points;
    logic [ERR_W-1:0]   error_code;

    modport source (
        output valid, frame_valid, dac_frame, last, laser_duty_ns, running,
               batch_points, played_points, error_code,
        input  ready
    );
    modport sink (
        input  valid, frame_valid, dac_frame, last, laser_duty_ns, running,
               batch_points, played_points, error_code,
        output ready
    );
endinterface

@@ hdl/gps_ram.sv @@
// Generic single write port RAM with a registered read port.
module gps_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 4096,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/gps_ctrl.sv @@
// Controller state machine sequencing accept, store read and result issue.
module gps_ctrl
    import gps_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_READ = 3'b010,
        S_EMIT = 3'b100
    } t_state;

    t_state            r_state, n_state;
    logic [STEP_W-1:0] r_step, n_step;

    always_comb begin
        n_state           = r_state;
        n_step            = r_step;
        o_cmd             = '0;
        o_cmd.step        = r_step;
        unique case (r_state)
            S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_req_valid) begin
                    o_cmd.accept = 1'b1;
                    n_step       = '0;
                    n_state      = i_status.due ? S_READ : S_EMIT;
                end
            end
            S_READ: begin
                o_cmd.latch_point = 1'b1;
                n_state           = S_EMIT;
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_step = r_step + 1'b1;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end
endmodule

@@ hdl/gps_dp.sv @@
// Datapath with the point stores, batch state and the result register.
module gps_dp
    import gps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    output t_dp_status         o_status,
    input  logic               i_enable,
    input  logic [CMD_W-1:0]   i_command,
    input  logic [IDX_W-1:0]   i_point_index,
    input  logic [CODE_W-1:0]  i_x_value,
    input  logic [CODE_W-1:0]  i_y_value,
    input  logic [CODE_W-1:0]  i_duty_permille,
    input  logic [DELAY_W-1:0] i_hold_us,
    input  logic [CNT_W-1:0]   i_point_count,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic               o_frame_valid,
    output logic [FRAME_W-1:0] o_dac_frame,
    output logic               o_last,
    output logic [LASER_W-1:0] o_laser_duty_ns,
    output logic               o_running,
    output logic [CNT_W-1:0]   o_batch_points,
    output logic [CNT_W-1:0]   o_played_points,
    output logic [ERR_W-1:0]   o_error_code
);
    logic [CMD_W-1:0]   r_cmd;
    logic [CODE_W-1:0]  r_x, r_y;
    logic [ERR_W-1:0]   r_err, n_err;
    logic [CNT_W-1:0]   r_batch_total, n_batch_total;
    logic [CNT_W-1:0]   r_next_point, n_next_point;
    logic [DELAY_W-1:0] r_wait_left, n_wait_left;
    logic [LASER_W-1:0] r_laser, n_laser;
    logic               r_due, n_due;
    logic [STEP_W-1:0]  r_nres, n_nres;

    logic               r_out_valid;
    logic               r_frame_valid;
    logic [FRAME_W-1:0] r_dac_frame;
    logic               r_last;
    logic [LASER_W-1:0] r_laser_out;
    logic               r_running;
    logic [CNT_W-1:0]   r_total_out, r_completed_out;
    logic [ERR_W-1:0]   r_err_out;

    logic               running;
    logic               tick_due;
    logic               store_we;
    logic [DUTY_W-1:0]  duty_clamped;
    logic [POS_W-1:0]   pos_rd;
    logic [TIM_W-1:0]   tim_rd;
    logic [CNT_W-1:0]   next_inc;
    logic               clear_now;
    logic               f_valid;
    logic [FRAME_W-1:0] f_frame;

    assign running  = r_next_point < r_batch_total;
    assign tick_due = (i_command == CMD_TICK) && running && (r_wait_left <= 32'd1);
    assign store_we = i_cmd.accept && (i_command == CMD_LOAD)
                      && (32'(i_point_index) < POINT_DEPTH);
    assign duty_clamped = (i_duty_permille > 16'(DUTY_MAX)) ? DUTY_MAX
                                                            : DUTY_W'(i_duty_permille);
    assign next_inc = r_next_point + 1'b1;
    assign clear_now = i_cmd.emit && r_due && (i_cmd.step == 3'd2);

    assign o_status.due      = tick_due;
    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_status.last     = (STEP_W'(i_cmd.step + 1'b1) == r_nres);

    gps_ram #(.WIDTH(POS_W), .DEPTH(POINT_DEPTH)) u_pos_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (PT_AW'(i_point_index)),
        .i_wdata ({i_x_value, i_y_value}),
        .i_re    (i_cmd.accept && tick_due),
        .i_raddr (PT_AW'(r_next_point)),
        .o_rdata (pos_rd)
    );

    gps_ram #(.WIDTH(TIM_W), .DEPTH(POINT_DEPTH)) u_tim_ram (
        .i_clk   (i_clk),
        .i_we    (store_we),
        .i_waddr (PT_AW'(i_point_index)),
        .i_wdata ({duty_clamped, i_hold_us}),
        .i_re    (i_cmd.accept && tick_due),
        .i_raddr (PT_AW'(r_next_point)),
        .o_rdata (tim_rd)
    );

    always_comb begin
        n_err         = r_err;
        n_batch_total = r_batch_total;
        n_next_point  = r_next_point;
        n_wait_left   = r_wait_left;
        n_laser       = r_laser;
        n_due         = r_due;
        n_nres        = r_nres;
        if (i_cmd.accept) begin
            n_err  = ERR_NONE;
            n_due  = tick_due;
            n_nres = NRES_ONE;
            unique case (i_command)
                CMD_START: begin
                    if (i_point_count != '0) begin
                        if (!i_enable) begin
                            n_err = ERR_DISABLED;
                        end else if (32'(i_point_count) > POINT_DEPTH) begin
                            n_err = ERR_RANGE;
                        end else begin
                            n_batch_total = i_point_count;
                            n_next_point  = '0;
                            n_wait_left   = '0;
                        end
                    end
                end
                CMD_TICK: begin
                    if (!running) begin
                        n_laser = '0;
                    end else if (r_wait_left > 32'd1) begin
                        n_wait_left = r_wait_left - 1'b1;
                    end else begin
                        n_nres = NRES_TWO;
                    end
                end
                CMD_HOME: begin
                    n_next_point = r_batch_total;
                    n_laser      = '0;
                    n_nres       = NRES_TWO;
                end
                CMD_SETPOS: n_nres = NRES_TWO;
                CMD_INIT:   n_nres = NRES_INIT;
                default:    n_nres = NRES_ONE;
            endcase
        end
        if (i_cmd.latch_point) begin
            n_laser      = LASER_W'({{(LASER_W-DUTY_W){1'b0}}, tim_rd[TIM_W-1:DELAY_W]}
                                    * NS_PER_PERMILLE);
            n_wait_left  = tim_rd[DELAY_W-1:0];
            n_next_point = next_inc;
            n_nres       = (next_inc >= r_batch_total) ? NRES_THREE : NRES_TWO;
        end
        if (clear_now) begin
            n_laser = '0;
        end
    end

    always_comb begin
        f_valid = 1'b0;
        f_frame = '0;
        unique case (r_cmd)
            CMD_TICK: begin
                if (r_due && (i_cmd.step == 3'd0)) begin
                    f_valid = 1'b1;
                    f_frame = {DAC_CMD_A, pos_rd[POS_W-1:CODE_W]};
                end else if (r_due && (i_cmd.step == 3'd1)) begin
                    f_valid = 1'b1;
                    f_frame = {DAC_CMD_B, pos_rd[CODE_W-1:0]};
                end
            end
            CMD_HOME: begin
                f_valid = 1'b1;
                f_frame = (i_cmd.step == 3'd0) ? {DAC_CMD_A, MID_CODE} : {DAC_CMD_B, MID_CODE};
            end
            CMD_SETPOS: begin
                f_valid = 1'b1;
                f_frame = (i_cmd.step == 3'd0) ? {DAC_CMD_A, r_x} : {DAC_CMD_B, r_y};
            end
            CMD_INIT: begin
                f_valid = 1'b1;
                f_frame = init_frame(i_cmd.step);
            end
            default: begin
                f_valid = 1'b0;
                f_frame = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err         <= ERR_NONE;
            r_batch_total <= '0;
            r_next_point  <= '0;
            r_wait_left   <= '0;
            r_laser       <= '0;
            r_due         <= 1'b0;
            r_nres        <= NRES_ONE;
            r_out_valid   <= 1'b0;
        end else begin
            r_err         <= n_err;
            r_batch_total <= n_batch_total;
            r_next_point  <= n_next_point;
            r_wait_left   <= n_wait_left;
            r_laser       <= n_laser;
            r_due         <= n_due;
            r_nres        <= n_nres;
            if (i_cmd.emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_cmd <= i_command;
            r_x   <= i_x_value;
            r_y   <= i_y_value;
        end
        if (i_cmd.emit) begin
            r_frame_valid   <= f_valid;
            r_dac_frame     <= f_frame;
            r_last          <= o_status.last;
            r_laser_out     <= clear_now ? '0 : r_laser;
            r_running       <= running;
            r_total_out     <= r_batch_total;
            r_completed_out <= r_next_point;
            r_err_out       <= r_err;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_frame_valid   = r_frame_valid;
    assign o_dac_frame     = r_dac_frame;
    assign o_last          = r_last;
    assign o_laser_duty_ns = r_laser_out;
    assign o_running       = r_running;
    assign o_batch_points  = r_total_out;
    assign o_played_points = r_completed_out;
    assign o_error_code    = r_err_out;
endmodule

@@ hdl/galvo_point_sequencer_top.sv @@
// Laser galvo point sequencer: a request is accepted in the idle state, a tick that plays a point
// then passes through a store read state, and results follow, one result per cycle while the sink is
// ready. A new request is not taken until the last result of the previous one has been issued.
// The store read port and the single result register lie between a request and its results.
// Reset is synchronous and active low: batch state and laser level clear, enable returns to 1,
// and the point stores hold undefined data until loaded.
module galvo_point_sequencer_top
    import gps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    gps_req_if.sink            i_req,
    gps_rsp_if.source          o_rsp,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [31:0]        i_pwdata,
    output logic [31:0]        o_prdata,
    output logic               o_pready
);
    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       r_enable;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b1;
        end else if (i_psel && i_penable && i_pwrite && (i_paddr[2] == REG_ENABLE)) begin
            r_enable <= i_pwdata[0];
        end
    end

    assign o_pready = 1'b1;
    assign o_prdata = (i_paddr[2] == REG_ENABLE) ? {31'd0, r_enable} : 32'd0;

    assign i_req.ready = w_cmd.in_ready;

    gps_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    gps_dp u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .i_enable        (r_enable),
        .i_command       (i_req.command),
        .i_point_index   (i_req.point_index),
        .i_x_value       (i_req.x_value),
        .i_y_value       (i_req.y_value),
        .i_duty_permille (i_req.duty_permille),
        .i_hold_us       (i_req.hold_us),
        .i_point_count   (i_req.point_count),
        .i_out_ready     (o_rsp.ready),
        .o_out_valid     (o_rsp.valid),
        .o_frame_valid   (o_rsp.frame_valid),
        .o_dac_frame     (o_rsp.dac_frame),
        .o_last          (o_rsp.last),
        .o_laser_duty_ns (o_rsp.laser_duty_ns),
        .o_running       (o_rsp.running),
        .o_batch_points  (o_rsp.batch_points),
        .o_played_points (o_rsp.played_points),
        .o_error_code    (o_rsp.error_code)
    );
endmodule

@@ tb/galvo_point_checker.sv @@
`timescale 1ns / 1ps
// Checker that predicts the sequencer's frame and status results and compares them.
module galvo_point_checker
    import gps_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    gps_req_if                 i_req,
    gps_rsp_if                 i_rsp,
    input  logic               i_psel,
    input  logic               i_penable,
    input  logic               i_pwrite,
    input  logic [PADDR_W-1:0] i_paddr,
    input  logic [31:0]        i_pwdata,
    input  logic               i_pready,
    output int                 o_fail_count,
    output int                 o_pending
);

    localparam logic [PADDR_W-1:0] ENABLE_ADDR  = {REG_ENABLE, 2'b00};
    localparam int                 REPORT_LIMIT = 10;

    typedef struct packed {
        logic               frame_valid;
        logic [FRAME_W-1:0] dac_frame;
        logic               last;
        logic [LASER_W-1:0] laser_duty_ns;
        logic               running;
        logic [CNT_W-1:0]   batch_points;
        logic [CNT_W-1:0]   played_points;
        logic [ERR_W-1:0]   error_code;
    } t_frame_status;

    logic [POS_W-1:0]   xy_mem   [POINT_DEPTH];
    logic [DUTY_W-1:0]  duty_mem [POINT_DEPTH];
    logic [DELAY_W-1:0] hold_mem [POINT_DEPTH];
    logic [CNT_W-1:0]   batch_len;
    logic [CNT_W-1:0]   play_idx;
    logic [DELAY_W-1:0] hold_left;
    logic [LASER_W-1:0] laser_ns;
    logic               enable_bit;
    t_frame_status      frame_status_q [$];
    int                 mismatch_count = 0;

    assign o_fail_count = mismatch_count;

    function automatic void push_result(input logic fv, input logic [FRAME_W-1:0] frame,
                                        input logic [ERR_W-1:0] err, input logic is_last);
        t_frame_status r;
        r.frame_valid   = fv;
        r.dac_frame     = fv ? frame : '0;
        r.last          = is_last;
        r.laser_duty_ns = laser_ns;
        r.running       = (play_idx < batch_len);
        r.batch_points  = batch_len;
        r.played_points = play_idx;
        r.error_code    = err;
        frame_status_q.push_back(r);
    endfunction

    function automatic void sequence_step(
        input logic [CMD_W-1:0]   cmd,
        input logic [IDX_W-1:0]   idx,
        input logic [CODE_W-1:0]  x,
        input logic [CODE_W-1:0]  y,
        input logic [CODE_W-1:0]  duty,
        input logic [DELAY_W-1:0] delay,
        input logic [CNT_W-1:0]   count
    );
        logic [DUTY_W-1:0] duty_c;
        logic [ERR_W-1:0]  err;
        logic [POS_W-1:0]  xy;
        err    = ERR_NONE;
        duty_c = (duty > CODE_W'(DUTY_MAX)) ? DUTY_MAX : duty[DUTY_W-1:0];
        case (cmd)
            CMD_LOAD: begin
                if (int'(idx) < POINT_DEPTH) begin
                    xy_mem[idx]   = {x, y};
                    duty_mem[idx] = duty_c;
                    hold_mem[idx] = delay;
                end
                push_result(1'b0, '0, ERR_NONE, 1'b1);
            end
            CMD_START: begin
                if (count != '0) begin
                    if (!enable_bit) begin
                        err = ERR_DISABLED;
                    end else if (int'(count) > POINT_DEPTH) begin
                        err = ERR_RANGE;
                    end else begin
                        batch_len = count;
                        play_idx  = '0;
                        hold_left = '0;
                    end
                end
                push_result(1'b0, '0, err, 1'b1);
            end
            CMD_TICK: begin
                if (play_idx >= batch_len || int'(play_idx) >= POINT_DEPTH) begin
                    laser_ns = '0;
                    push_result(1'b0, '0, ERR_NONE, 1'b1);
                end else if (hold_left > 1) begin
                    hold_left = hold_left - 1'b1;
                    push_result(1'b0, '0, ERR_NONE, 1'b1);
                end else begin
                    xy        = xy_mem[play_idx[PT_AW-1:0]];
                    laser_ns  = LASER_W'(duty_mem[play_idx[PT_AW-1:0]]) * NS_PER_PERMILLE;
                    hold_left = hold_mem[play_idx[PT_AW-1:0]];
                    play_idx  = play_idx + 1'b1;
                    push_result(1'b1, {DAC_CMD_A, xy[POS_W-1:CODE_W]}, ERR_NONE, 1'b0);
                    push_result(1'b1, {DAC_CMD_B, xy[CODE_W-1:0]}, ERR_NONE,
                                play_idx < batch_len);
                    if (play_idx >= batch_len) begin
                        laser_ns = '0;
                        push_result(1'b0, '0, ERR_NONE, 1'b1);
                    end
                end
            end
            CMD_HOME: begin
                play_idx = batch_len;
                laser_ns = '0;
                push_result(1'b1, {DAC_CMD_A, MID_CODE}, ERR_NONE, 1'b0);
                push_result(1'b1, {DAC_CMD_B, MID_CODE}, ERR_NONE, 1'b1);
            end
            CMD_SETPOS: begin
                push_result(1'b1, {DAC_CMD_A, x}, ERR_NONE, 1'b0);
                push_result(1'b1, {DAC_CMD_B, y}, ERR_NONE, 1'b1);
            end
            CMD_INIT: begin
                push_result(1'b1, {DAC_CMD_RESET, DAC_DATA_ONE}, ERR_NONE, 1'b0);
                push_result(1'b1, {DAC_CMD_REF, DAC_DATA_ONE}, ERR_NONE, 1'b0);
                push_result(1'b1, {DAC_CMD_LDAC, DAC_DATA_BOTH}, ERR_NONE, 1'b0);
                push_result(1'b1, {DAC_CMD_A, MID_CODE}, ERR_NONE, 1'b0);
                push_result(1'b1, {DAC_CMD_B, MID_CODE}, ERR_NONE, 1'b1);
            end
            default: begin
                push_result(1'b0, '0, ERR_NONE, 1'b1);
            end
        endcase
    endfunction

    function automatic void check_result();
        t_frame_status seen;
        t_frame_status want;
        seen.frame_valid   = i_rsp.frame_valid;
        seen.dac_frame     = i_rsp.dac_frame;
        seen.last          = i_rsp.last;
        seen.laser_duty_ns = i_rsp.laser_duty_ns;
        seen.running       = i_rsp.running;
        seen.batch_points  = i_rsp.batch_points;
        seen.played_points = i_rsp.played_points;
        seen.error_code    = i_rsp.error_code;
        if (frame_status_q.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT) begin
                $display("%0t: unexpected result: fv=%0b frame=%06h last=%0b", $realtime,
                         seen.frame_valid, seen.dac_frame, seen.last);
            end
            mismatch_count++;
        end else begin
            want = frame_status_q.pop_front();
            if (seen !== want) begin
                if (mismatch_count < REPORT_LIMIT) begin
                    $display("%0t: mismatch expected fv=%0b frame=%06h last=%0b laser=%0d",
                             $realtime, want.frame_valid, want.dac_frame, want.last,
                             want.laser_duty_ns);
                    $display("    run=%0b total=%0d done=%0d err=%0d", want.running,
                             want.batch_points, want.played_points, want.error_code);
                    $display("  actual fv=%0b frame=%06h last=%0b laser=%0d",
                             seen.frame_valid, seen.dac_frame, seen.last, seen.laser_duty_ns);
                    $display("    run=%0b total=%0d done=%0d err=%0d", seen.running,
                             seen.batch_points, seen.played_points, seen.error_code);
                end
                mismatch_count++;
            end
        end
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            batch_len  = '0;
            play_idx   = '0;
            hold_left  = '0;
            laser_ns   = '0;
            enable_bit = 1'b1;
            frame_status_q.delete();
        end else begin
            if (i_psel && i_penable && i_pwrite && i_pready && i_paddr == ENABLE_ADDR) begin
                enable_bit = i_pwdata[0];
            end
            if (i_rsp.valid && i_rsp.ready) begin
                check_result();
            end
            if (i_req.valid && i_req.ready) begin
                sequence_step(i_req.command, i_req.point_index, i_req.x_value, i_req.y_value,
                              i_req.duty_permille, i_req.hold_us, i_req.point_count);
            end
        end
        o_pending <= frame_status_q.size();
    end

endmodule

@@ tb/tb_galvo_point_sequencer_top.sv @@
`timescale 1ns / 1ps
// Testbench top that drives requests and register writes into the sequencer and gives the verdict.
module tb_galvo_point_sequencer_top;
    import gps_pkg::*;

    localparam logic [PADDR_W-1:0] ENABLE_ADDR    = {REG_ENABLE, 2'b00};
    localparam logic [CMD_W-1:0]   CMD_RSVD_LO    = 3'd6;
    localparam logic [CMD_W-1:0]   CMD_RSVD_HI    = 3'd7;
    localparam int                 SETTLE_CYCLES  = 6;
    localparam int                 HOLD_CYCLES    = 300;
    localparam int                 WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [IDX_W-1:0]   point_index;
        logic [CODE_W-1:0]  x_value;
        logic [CODE_W-1:0]  y_value;
        logic [CODE_W-1:0]  duty_permille;
        logic [DELAY_W-1:0] hold_us;
        logic [CNT_W-1:0]   point_count;
    } t_galvo_req;

    logic               i_clk;
    logic               i_rst_n;
    logic               psel;
    logic               penable;
    logic               pwrite;
    logic [PADDR_W-1:0] paddr;
    logic [31:0]        pwdata;
    logic [31:0]        prdata;
    logic               pready;
    logic               hold_rx;
    int                 rx_idle_pct;
    int                 tx_idle_pct;
    int                 fail_count;
    int                 pending;
    int                 idle_cycles;

    bit                 loaded_map [POINT_DEPTH];
    int                 loaded_prefix = 0;
    bit                 batch_armed = 1'b0;
    int                 ticks_since_start = 0;
    logic               enable_shadow = 1'b1;

    gps_req_if req_if ();
    gps_rsp_if rsp_if ();

    galvo_point_sequencer_top DUT (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (req_if),
        .o_rsp     (rsp_if),
        .i_psel    (psel),
        .i_penable (penable),
        .i_pwrite  (pwrite),
        .i_paddr   (paddr),
        .i_pwdata  (pwdata),
        .o_prdata  (prdata),
        .o_pready  (pready)
    );

    galvo_point_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_if),
        .i_rsp        (rsp_if),
        .i_psel       (psel),
        .i_penable    (penable),
        .i_pwrite     (pwrite),
        .i_paddr      (paddr),
        .i_pwdata     (pwdata),
        .i_pready     (pready),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        rsp_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            rsp_if.ready <= !hold_rx && ($urandom_range(99) >= rx_idle_pct);
        end
    end

    initial begin
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("galvo_point_sequencer_top verification failed");
        $finish;
    end

    function automatic t_galvo_req make_item(
        input logic [CMD_W-1:0]   cmd,
        input logic [IDX_W-1:0]   idx,
        input logic [CODE_W-1:0]  x,
        input logic [CODE_W-1:0]  y,
        input logic [CODE_W-1:0]  duty,
        input logic [DELAY_W-1:0] delay,
        input logic [CNT_W-1:0]   count
    );
        t_galvo_req rq;
        rq.command       = cmd;
        rq.point_index   = idx;
        rq.x_value       = x;
        rq.y_value       = y;
        rq.duty_permille = duty;
        rq.hold_us       = delay;
        rq.point_count   = count;
        return rq;
    endfunction

    // Ticks are only offered while every point they could play has been loaded.
    function automatic t_galvo_req random_item();
        t_galvo_req rq;
        int         pick;
        int         sel;
        int         span;
        rq.command       = CMD_TICK;
        rq.point_index   = IDX_W'($urandom);
        rq.x_value       = CODE_W'($urandom);
        rq.y_value       = CODE_W'($urandom);
        rq.duty_permille = CODE_W'($urandom);
        rq.hold_us       = $urandom;
        rq.point_count   = CNT_W'($urandom);
        pick = $urandom_range(99);
        sel  = $urandom_range(99);
        if (pick < 45) begin
            if (batch_armed && ticks_since_start >= loaded_prefix) begin
                rq.command = CMD_HOME;
            end
        end else if (pick < 65) begin
            rq.command = CMD_LOAD;
            if (loaded_prefix < POINT_DEPTH && $urandom_range(99) < 80) begin
                rq.point_index = IDX_W'(loaded_prefix);
            end
            if (sel < 70) begin
                rq.duty_permille = CODE_W'($urandom_range(1000));
            end else if (sel < 85) begin
                rq.duty_permille = CODE_W'($urandom_range(65535, 1001));
            end
            sel = $urandom_range(99);
            if (sel < 55) begin
                rq.hold_us = $urandom_range(3);
            end else if (sel < 95) begin
                rq.hold_us = $urandom_range(12, 4);
            end
        end else if (pick < 75) begin
            rq.command = CMD_START;
            span = (loaded_prefix > 24) ? 24 : ((loaded_prefix > 0) ? loaded_prefix : 1);
            if (sel < 8) begin
                rq.point_count = '0;
            end else if (sel < 16) begin
                rq.point_count = CNT_W'($urandom_range(8191, POINT_DEPTH + 1));
            end else if (sel < 20) begin
                rq.point_count = CNT_W'(POINT_DEPTH);
            end else if (sel < 26) begin
                rq.point_count = CNT_W'($urandom_range(POINT_DEPTH, 1));
            end else begin
                rq.point_count = CNT_W'($urandom_range(span, 1));
            end
        end else if (pick < 83) begin
            rq.command = CMD_SETPOS;
        end else if (pick < 89) begin
            rq.command = CMD_HOME;
        end else if (pick < 94) begin
            rq.command = CMD_INIT;
        end else begin
            rq.command = ($urandom_range(1) == 1) ? CMD_RSVD_HI : CMD_RSVD_LO;
        end
        return rq;
    endfunction

    task automatic issue(input t_galvo_req rq);
        case (rq.command)
            CMD_LOAD: begin
                loaded_map[rq.point_index] = 1'b1;
                while (loaded_prefix < POINT_DEPTH && loaded_map[loaded_prefix]) begin
                    loaded_prefix++;
                end
            end
            CMD_START: begin
                if (rq.point_count != '0 && enable_shadow
                        && int'(rq.point_count) <= POINT_DEPTH) begin
                    batch_armed       = 1'b1;
                    ticks_since_start = 0;
                end
            end
            CMD_TICK: begin
                ticks_since_start++;
            end
            CMD_HOME: begin
                batch_armed = 1'b0;
            end
            default: begin
            end
        endcase
        while ($urandom_range(99) < tx_idle_pct) begin
            req_if.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_if.valid         <= 1'b1;
        req_if.command       <= rq.command;
        req_if.point_index   <= rq.point_index;
        req_if.x_value       <= rq.x_value;
        req_if.y_value       <= rq.y_value;
        req_if.duty_permille <= rq.duty_permille;
        req_if.hold_us       <= rq.hold_us;
        req_if.point_count   <= rq.point_count;
        do @(posedge i_clk); while (!req_if.ready);
    endtask

    task automatic run_random(input int n);
        repeat (n) issue(random_item());
    endtask

    task automatic drain_block();
        req_if.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_enable(input logic value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ENABLE_ADDR;
        pwdata  <= {31'd0, value};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        enable_shadow = value;
    endtask

    initial begin
        i_rst_n              <= 1'b0;
        psel                 <= 1'b0;
        penable              <= 1'b0;
        pwrite               <= 1'b0;
        paddr                <= '0;
        pwdata               <= '0;
        hold_rx              <= 1'b0;
        rx_idle_pct          <= 76;
        tx_idle_pct          = 31;
        req_if.valid         <= 1'b0;
        req_if.command       <= CMD_LOAD;
        req_if.point_index   <= '0;
        req_if.x_value       <= '0;
        req_if.y_value       <= '0;
        req_if.duty_permille <= '0;
        req_if.hold_us       <= '0;
        req_if.point_count   <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        write_enable(1'b1);

        issue(make_item(CMD_INIT, '0, '0, '0, '0, '0, '0));
        issue(make_item(CMD_TICK, '0, '0, '0, '0, '0, '0));
        issue(make_item(CMD_SETPOS, '0, 16'h0000, 16'h0000, '0, '0, '0));
        issue(make_item(CMD_SETPOS, '0, 16'hFFFF, 16'hFFFF, '0, '0, '0));
        issue(make_item(CMD_RSVD_LO, '0, '0, '0, '0, '0, '0));
        issue(make_item(CMD_RSVD_HI, '0, '0, '0, '0, '0, '0));
        issue(make_item(CMD_LOAD, 12'd0, 16'hFFFF, 16'h0000, 16'hFFFF, 32'd0, '0));
        issue(make_item(CMD_LOAD, 12'd1, 16'h0000, 16'hFFFF, 16'd0, 32'd2, '0));
        issue(make_item(CMD_LOAD, 12'd2, 16'h8001, 16'h7FFE, 16'd1000, 32'hFFFF_FFFF, '0));
        issue(make_item(CMD_LOAD, 12'd3, 16'h5A5A, 16'hA5A5, 16'd1001, 32'd1, '0));
        issue(make_item(CMD_LOAD, 12'hFFF, 16'h1234, 16'hFEDC, 16'd999, 32'd7, '0));
        issue(make_item(CMD_START, '0, '0, '0, '0, '0, '0));
        issue(make_item(CMD_START, '0, '0, '0, '0, '0, CNT_W'(POINT_DEPTH + 1)));
        issue(make_item(CMD_START, '0, '0, '0, '0, '0, CNT_W'(8191)));
        issue(make_item(CMD_START, '0, '0, '0, '0, '0, CNT_W'(3)));
        repeat (5) issue(make_item(CMD_TICK, '0, '0, '0, '0, '0, '0));
        issue(make_item(CMD_START, '0, '0, '0, '0, '0, CNT_W'(POINT_DEPTH)));
        issue(make_item(CMD_TICK, '0, '0, '0, '0, '0, '0));
        issue(make_item(CMD_HOME, '0, '0, '0, '0, '0, '0));
        drain_block();
        write_enable(1'b0);
        issue(make_item(CMD_START, '0, '0, '0, '0, '0, CNT_W'(2)));
        issue(make_item(CMD_START, '0, '0, '0, '0, '0, '0));
        drain_block();
        write_enable(1'b1);

        run_random(90);
        drain_block();
        write_enable(1'b0);
        tx_idle_pct = 76;
        rx_idle_pct <= 31;
        run_random(25);
        drain_block();
        write_enable(1'b1);
        run_random(70);
        drain_block();

        // The sink stalls for a long stretch while requests keep coming.
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        fork
            begin
                hold_rx <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_rx <= 1'b0;
            end
        join_none
        run_random(95);
        drain_block();

        if (fail_count == 0 && pending == 0) begin
            $display("galvo_point_sequencer_top verification clean");
        end else begin
            $display("galvo_point_sequencer_top verification failed");
        end
        $finish;
    end

endmodule
